FILE: rtl/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
`timescale 1ns / 1ps

package tksd_pkg;

  localparam int unsigned CodeW = 21;

  typedef enum logic [3:0] {
    KeyChar      = 4'd0,
    KeyEnter     = 4'd1,
    KeyTab       = 4'd2,
    KeyBackspace = 4'd3,
    KeyEscape    = 4'd4,
    KeyUp        = 4'd5,
    KeyDown      = 4'd6,
    KeyRight     = 4'd7,
    KeyLeft      = 4'd8,
    KeyHome      = 4'd9,
    KeyEnd       = 4'd10,
    KeyDelete    = 4'd11,
    KeyPgUp      = 4'd12,
    KeyPgDn      = 4'd13
  } key_kind_e;

  typedef enum logic {
    ReqByte = 1'b0,
    ReqIdle = 1'b1
  } req_type_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    key_kind_e         kind;
    logic [CodeW-1:0]  char_code;
    logic              ctrl;
    logic              alt;
  } key_evt_t;

  // Final letter of a plain CSI or SS3 sequence; KeyChar when unknown.
  function automatic key_kind_e letter_key(logic [7:0] b);
    key_kind_e k;
    case (b)
      8'h41:   k = KeyUp;
      8'h42:   k = KeyDown;
      8'h43:   k = KeyRight;
      8'h44:   k = KeyLeft;
      8'h48:   k = KeyHome;
      8'h46:   k = KeyEnd;
      default: k = KeyChar;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/tksd_in_stage.sv
// Input register stage: holds one accepted input transaction.
`timescale 1ns / 1ps

module tksd_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  logic [7:0]     in_byte_i,
  input  logic           take_i,
  output logic           item_valid_o,
  output tksd_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  tksd_pkg::item_t item_q;
  logic            accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.req_type <= req_type_i;
      item_q.in_byte  <= in_byte_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: rtl/tksd_decode.sv
// Parser state and per-byte decode logic producing at most one key event.
`timescale 1ns / 1ps

module tksd_decode #(
  parameter int unsigned PARAM_LIMIT = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tksd_pkg::item_t     item_i,
  output logic                evt_valid_o,
  output tksd_pkg::key_evt_t  evt_o
);

  localparam int unsigned PosW = $clog2(PARAM_LIMIT + 1);
  localparam int unsigned CW   = tksd_pkg::CodeW;

  localparam logic [7:0] ByteEsc   = 8'd27;
  localparam logic [7:0] ByteCr    = 8'd13;
  localparam logic [7:0] ByteHt    = 8'd9;
  localparam logic [7:0] ByteDel   = 8'd127;
  localparam logic [7:0] ByteSpace = 8'd32;
  localparam logic [7:0] ByteAt    = 8'h40;
  localparam logic [7:0] ByteCsi   = 8'h5B;
  localparam logic [7:0] ByteSs3   = 8'h4F;
  localparam logic [7:0] ByteZero  = 8'h30;
  localparam logic [7:0] ByteNine  = 8'h39;
  localparam logic [7:0] ByteOne   = 8'h31;
  localparam logic [7:0] ByteThree = 8'h33;
  localparam logic [7:0] ByteFour  = 8'h34;
  localparam logic [7:0] ByteFive  = 8'h35;
  localparam logic [7:0] ByteSix   = 8'h36;
  localparam logic [7:0] ByteSemi  = 8'h3B;
  localparam logic [7:0] ByteTilde = 8'h7E;
  localparam logic [7:0] ByteA     = 8'h41;
  localparam logic [7:0] ByteB     = 8'h42;
  localparam logic [7:0] ByteC     = 8'h43;
  localparam logic [7:0] ByteD     = 8'h44;
  localparam logic [7:0] Lead2     = 8'hC0;
  localparam logic [7:0] Lead3     = 8'hE0;
  localparam logic [7:0] Lead4     = 8'hF0;

  typedef enum logic [5:0] {
    PhIdle  = 6'b000001,
    PhUtf8  = 6'b000010,
    PhEsc   = 6'b000100,
    PhCsi   = 6'b001000,
    PhParam = 6'b010000,
    PhSs3   = 6'b100000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [1:0]      rem_q, rem_d;
  logic [CW-1:0]   acc_q, acc_d;
  logic [7:0]      fpc_q, fpc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            semi_q, semi_d;
  logic            ctrls_q, ctrls_d;

  logic               idle;
  logic [7:0]         b;
  logic [1:0]         rem_n;
  logic [PosW-1:0]    pos_n;
  tksd_pkg::key_kind_e k;
  logic               evt_valid;
  tksd_pkg::key_evt_t evt;

  assign idle  = (item_i.req_type == tksd_pkg::ReqIdle);
  assign b     = item_i.in_byte;
  assign rem_n = (rem_q != 2'd0) ? rem_q - 2'd1 : 2'd0;
  assign pos_n = pos_q + PosW'(1);
  assign k     = tksd_pkg::letter_key(b);

  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    fpc_d     = fpc_q;
    pos_d     = pos_q;
    semi_d    = semi_q;
    ctrls_d   = ctrls_q;
    evt_valid = 1'b0;
    evt       = '{kind: tksd_pkg::KeyChar, char_code: '0, ctrl: 1'b0, alt: 1'b0};

    case (phase_q)
      PhUtf8: begin
        if (!idle) begin
          acc_d = {acc_q[CW-7:0], b[5:0]};
        end
        if (!idle && rem_n != 2'd0) begin
          rem_d = rem_n;
        end else begin
          phase_d        = PhIdle;
          rem_d          = 2'd0;
          evt_valid      = 1'b1;
          evt.char_code  = acc_d;
        end
      end

      PhEsc: begin
        if (idle) begin
          phase_d   = PhIdle;
          evt_valid = 1'b1;
          evt.kind  = tksd_pkg::KeyEscape;
        end else if (b == ByteCsi) begin
          phase_d = PhCsi;
        end else if (b == ByteSs3) begin
          phase_d = PhSs3;
        end else begin
          phase_d       = PhIdle;
          evt_valid     = 1'b1;
          evt.char_code = CW'(b);
          evt.alt       = 1'b1;
        end
      end

      PhCsi: begin
        if (idle) begin
          phase_d   = PhIdle;
          evt_valid = 1'b1;
          evt.kind  = tksd_pkg::KeyEscape;
        end else if (b >= ByteZero && b <= ByteNine) begin
          fpc_d   = b;
          pos_d   = PosW'(2);
          semi_d  = 1'b0;
          ctrls_d = 1'b0;
          phase_d = PhParam;
        end else begin
          phase_d   = PhIdle;
          evt_valid = (k != tksd_pkg::KeyChar);
          evt.kind  = k;
        end
      end

      PhParam: begin
        if (idle) begin
          phase_d = PhIdle;
        end else if (b >= ByteAt) begin
          phase_d = PhIdle;
          if (b == ByteA || b == ByteB || b == ByteC || b == ByteD) begin
            evt_valid = 1'b1;
            evt.kind  = k;
            evt.ctrl  = ctrls_q;
          end else if (b == ByteTilde) begin
            evt_valid = 1'b1;
            case (fpc_q)
              ByteThree: evt.kind = tksd_pkg::KeyDelete;
              ByteFive:  evt.kind = tksd_pkg::KeyPgUp;
              ByteSix:   evt.kind = tksd_pkg::KeyPgDn;
              ByteOne:   evt.kind = tksd_pkg::KeyHome;
              ByteFour:  evt.kind = tksd_pkg::KeyEnd;
              default:   evt_valid = 1'b0;
            endcase
          end
        end else begin
          if (semi_q && b == ByteFive) begin
            ctrls_d = 1'b1;
          end
          semi_d = (b == ByteSemi);
          pos_d  = pos_n;
          if (pos_n >= PosW'(PARAM_LIMIT)) begin
            phase_d = PhIdle;
          end
        end
      end

      PhSs3: begin
        phase_d = PhIdle;
        if (idle) begin
          evt_valid = 1'b1;
          evt.kind  = tksd_pkg::KeyEscape;
        end else begin
          evt_valid = (k != tksd_pkg::KeyChar);
          evt.kind  = k;
        end
      end

      default: begin
        phase_d = PhIdle;
        if (!idle) begin
          if (b == ByteEsc) begin
            phase_d = PhEsc;
          end else if (b == ByteCr) begin
            evt_valid = 1'b1;
            evt.kind  = tksd_pkg::KeyEnter;
          end else if (b == ByteHt) begin
            evt_valid = 1'b1;
            evt.kind  = tksd_pkg::KeyTab;
          end else if (b == ByteDel) begin
            evt_valid = 1'b1;
            evt.kind  = tksd_pkg::KeyBackspace;
          end else if (b < ByteSpace) begin
            evt_valid     = 1'b1;
            evt.char_code = CW'(b + ByteAt);
            evt.ctrl      = 1'b1;
          end else if (b >= Lead2) begin
            phase_d = PhUtf8;
            if (b < Lead3) begin
              rem_d = 2'd1;
              acc_d = CW'(b[4:0]);
            end else if (b < Lead4) begin
              rem_d = 2'd2;
              acc_d = CW'(b[3:0]);
            end else begin
              rem_d = 2'd3;
              acc_d = CW'(b[2:0]);
            end
          end else begin
            evt_valid     = 1'b1;
            evt.char_code = CW'(b);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      rem_q   <= 2'd0;
      acc_q   <= '0;
      fpc_q   <= 8'd0;
      pos_q   <= '0;
      semi_q  <= 1'b0;
      ctrls_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      fpc_q   <= fpc_d;
      pos_q   <= pos_d;
      semi_q  <= semi_d;
      ctrls_q <= ctrls_d;
    end
  end

  assign evt_valid_o = evt_valid;
  assign evt_o       = evt;

endmodule

FILE: rtl/tksd_out_stage.sv
// Result register stage: holds one key event until the consumer takes it.
`timescale 1ns / 1ps

module tksd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  tksd_pkg::key_evt_t  evt_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tksd_pkg::key_evt_t  evt_o
);

  logic               valid_q, valid_d;
  tksd_pkg::key_evt_t evt_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      evt_q <= evt_i;
    end
  end

  assign out_valid_o = valid_q;
  assign evt_o       = evt_q;

endmodule

FILE: rtl/terminal_key_sequence_decoder.sv
// Terminal key sequence decoder top level.
// Path: input register, then result register; a byte ending no key gives no result.
// Throughput: one input transaction per cycle, except while input ready is low.
// Input ready drops only while the result register is full and not being taken.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to idle.
`timescale 1ns / 1ps

module terminal_key_sequence_decoder #(
  parameter int unsigned PARAM_LIMIT = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  key_kind_o,
  output logic [20:0] char_code_o,
  output logic        ctrl_mod_o,
  output logic        alt_mod_o
);

  logic               take;
  logic               item_valid;
  tksd_pkg::item_t    item;
  logic               step;
  logic               evt_valid;
  tksd_pkg::key_evt_t evt;
  tksd_pkg::key_evt_t out_evt;

  assign step = item_valid && take;

  tksd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .in_byte_i   (in_byte_i),
    .take_i      (take),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  tksd_decode #(
    .PARAM_LIMIT(PARAM_LIMIT)
  ) u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .evt_valid_o(evt_valid),
    .evt_o      (evt)
  );

  tksd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && evt_valid),
    .evt_i      (evt),
    .free_o     (take),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .evt_o      (out_evt)
  );

  assign key_kind_o  = out_evt.kind;
  assign char_code_o = out_evt.char_code;
  assign ctrl_mod_o  = out_evt.ctrl;
  assign alt_mod_o   = out_evt.alt;

  a_code_only_on_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_kind_o != tksd_pkg::KeyChar |-> char_code_o == 21'd0)
    else $error("char_code set on a non-char key");

  a_alt_only_plain_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alt_mod_o |-> key_kind_o == tksd_pkg::KeyChar && !ctrl_mod_o)
    else $error("alt flag on an unexpected key");

  a_ctrl_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctrl_mod_o |->
      key_kind_o == tksd_pkg::KeyChar || key_kind_o == tksd_pkg::KeyUp ||
      key_kind_o == tksd_pkg::KeyDown || key_kind_o == tksd_pkg::KeyRight ||
      key_kind_o == tksd_pkg::KeyLeft)
    else $error("ctrl flag on an unexpected key");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule

FILE: verif/tksd_tb_pkg.sv
// Byte codes shared by the key decoder testbench and its checker.
`timescale 1ns / 1ps

package tksd_tb_pkg;

  localparam logic [7:0] ByteNul      = 8'h00;
  localparam logic [7:0] ByteTab      = 8'h09;
  localparam logic [7:0] ByteCr       = 8'h0D;
  localparam logic [7:0] ByteEsc      = 8'h1B;
  localparam logic [7:0] ByteSpace    = 8'h20;
  localparam logic [7:0] ByteDigit0   = 8'h30;
  localparam logic [7:0] ByteDigit1   = 8'h31;
  localparam logic [7:0] ByteDigit3   = 8'h33;
  localparam logic [7:0] ByteDigit4   = 8'h34;
  localparam logic [7:0] ByteDigit5   = 8'h35;
  localparam logic [7:0] ByteDigit6   = 8'h36;
  localparam logic [7:0] ByteDigit9   = 8'h39;
  localparam logic [7:0] ByteSemi     = 8'h3B;
  localparam logic [7:0] ByteFinalMin = 8'h40;
  localparam logic [7:0] ByteUp       = 8'h41;
  localparam logic [7:0] ByteDown     = 8'h42;
  localparam logic [7:0] ByteRight    = 8'h43;
  localparam logic [7:0] ByteLeft     = 8'h44;
  localparam logic [7:0] ByteEnd      = 8'h46;
  localparam logic [7:0] ByteHome     = 8'h48;
  localparam logic [7:0] ByteSs3      = 8'h4F;
  localparam logic [7:0] ByteCsi      = 8'h5B;
  localparam logic [7:0] ByteTilde    = 8'h7E;
  localparam logic [7:0] ByteDel      = 8'h7F;
  localparam logic [7:0] ByteCont     = 8'h80;
  localparam logic [7:0] ByteLead2    = 8'hC0;
  localparam logic [7:0] ByteLead3    = 8'hE0;
  localparam logic [7:0] ByteLead4    = 8'hF0;

endpackage

FILE: verif/tksd_checker.sv
// Checker for the key decoder: predicts key events from accepted bytes and compares results.
`timescale 1ns / 1ps

module tksd_checker
  import tksd_pkg::*;
  import tksd_tb_pkg::*;
#(
  parameter int unsigned PARAM_LIMIT = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        req_type_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  key_kind_i,
  input  logic [20:0] char_code_i,
  input  logic        ctrl_mod_i,
  input  logic        alt_mod_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhUtf8,
    PhEsc,
    PhCsi,
    PhParam,
    PhSs3
  } parse_phase_e;

  parse_phase_e     phase;
  logic [1:0]       utf8_left;
  logic [CodeW-1:0] cp_acc;
  logic [7:0]       first_digit;
  int               param_pos;
  logic             semi_seen;
  logic             ctrl_hit;

  key_evt_t expected_keys[$];
  int       fail_count;

  function automatic key_kind_e csi_letter_key(logic [7:0] b);
    key_kind_e k;
    k = KeyChar;
    if (b == ByteUp) k = KeyUp;
    else if (b == ByteDown) k = KeyDown;
    else if (b == ByteRight) k = KeyRight;
    else if (b == ByteLeft) k = KeyLeft;
    else if (b == ByteHome) k = KeyHome;
    else if (b == ByteEnd) k = KeyEnd;
    return k;
  endfunction

  task automatic clear_decoder();
    phase       = PhIdle;
    utf8_left   = '0;
    cp_acc      = '0;
    first_digit = '0;
    param_pos   = 0;
    semi_seen   = 1'b0;
    ctrl_hit    = 1'b0;
  endtask

  // One input transaction in, zero or one key event out.
  task automatic decode_key(input logic req, input logic [7:0] b);
    key_evt_t  evt;
    logic      hit;
    key_kind_e k;
    logic [1:0] extra;
    logic       idle;
    evt  = '0;
    hit  = 1'b0;
    idle = (req == ReqIdle);
    case (phase)
      PhUtf8: begin
        if (!idle) begin
          cp_acc = {cp_acc[CodeW-7:0], b[5:0]};
          if (utf8_left != 0) utf8_left = utf8_left - 1'b1;
        end
        if (idle || utf8_left == 0) begin
          phase         = PhIdle;
          utf8_left     = '0;
          hit           = 1'b1;
          evt.kind      = KeyChar;
          evt.char_code = cp_acc;
        end
      end
      PhEsc: begin
        if (idle) begin
          phase    = PhIdle;
          hit      = 1'b1;
          evt.kind = KeyEscape;
        end else if (b == ByteCsi) begin
          phase = PhCsi;
        end else if (b == ByteSs3) begin
          phase = PhSs3;
        end else begin
          phase         = PhIdle;
          hit           = 1'b1;
          evt.kind      = KeyChar;
          evt.char_code = CodeW'(b);
          evt.alt       = 1'b1;
        end
      end
      PhCsi: begin
        if (idle) begin
          phase    = PhIdle;
          hit      = 1'b1;
          evt.kind = KeyEscape;
        end else if (b >= ByteDigit0 && b <= ByteDigit9) begin
          first_digit = b;
          param_pos   = 2;
          semi_seen   = 1'b0;
          ctrl_hit    = 1'b0;
          phase       = PhParam;
        end else begin
          phase = PhIdle;
          k     = csi_letter_key(b);
          if (k != KeyChar) begin
            hit      = 1'b1;
            evt.kind = k;
          end
        end
      end
      PhParam: begin
        if (idle) begin
          phase = PhIdle;
        end else if (b >= ByteFinalMin) begin
          phase = PhIdle;
          if (b >= ByteUp && b <= ByteLeft) begin
            hit      = 1'b1;
            evt.kind = csi_letter_key(b);
            evt.ctrl = ctrl_hit;
          end else if (b == ByteTilde) begin
            hit = 1'b1;
            if (first_digit == ByteDigit3) evt.kind = KeyDelete;
            else if (first_digit == ByteDigit5) evt.kind = KeyPgUp;
            else if (first_digit == ByteDigit6) evt.kind = KeyPgDn;
            else if (first_digit == ByteDigit1) evt.kind = KeyHome;
            else if (first_digit == ByteDigit4) evt.kind = KeyEnd;
            else hit = 1'b0;
          end
        end else begin
          if (semi_seen && b == ByteDigit5) ctrl_hit = 1'b1;
          semi_seen = (b == ByteSemi);
          param_pos++;
          if (param_pos >= PARAM_LIMIT) phase = PhIdle;
        end
      end
      PhSs3: begin
        phase = PhIdle;
        if (idle) begin
          hit      = 1'b1;
          evt.kind = KeyEscape;
        end else begin
          k = csi_letter_key(b);
          if (k != KeyChar) begin
            hit      = 1'b1;
            evt.kind = k;
          end
        end
      end
      default: begin
        phase = PhIdle;
        if (!idle) begin
          hit = 1'b1;
          if (b == ByteEsc) begin
            hit   = 1'b0;
            phase = PhEsc;
          end else if (b == ByteCr) begin
            evt.kind = KeyEnter;
          end else if (b == ByteTab) begin
            evt.kind = KeyTab;
          end else if (b == ByteDel) begin
            evt.kind = KeyBackspace;
          end else if (b < ByteSpace) begin
            evt.kind      = KeyChar;
            evt.char_code = CodeW'(b) + CodeW'(ByteFinalMin);
            evt.ctrl      = 1'b1;
          end else if (b >= ByteLead2) begin
            hit       = 1'b0;
            extra     = (b < ByteLead3) ? 2'd1 : (b < ByteLead4) ? 2'd2 : 2'd3;
            cp_acc    = CodeW'(b & (8'h3F >> extra));
            utf8_left = extra;
            phase     = PhUtf8;
          end else begin
            evt.kind      = KeyChar;
            evt.char_code = CodeW'(b);
          end
        end
      end
    endcase
    if (hit) expected_keys.push_back(evt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    key_evt_t want;
    key_evt_t got;
    if (!rst_ni) begin
      clear_decoder();
      expected_keys.delete();
      fail_count = 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_key(req_type_i, in_byte_i);
      if (out_valid_i && out_ready_i) begin
        got.kind      = key_kind_e'(key_kind_i);
        got.char_code = char_code_i;
        got.ctrl      = ctrl_mod_i;
        got.alt       = alt_mod_i;
        if (expected_keys.size() == 0) begin
          fail_count++;
          $display("%0t chk: unexpected key kind=%0d code=%h ctrl=%b alt=%b",
                   $time, got.kind, got.char_code, got.ctrl, got.alt);
        end else begin
          want = expected_keys.pop_front();
          if (got.kind !== want.kind || got.char_code !== want.char_code ||
              got.ctrl !== want.ctrl || got.alt !== want.alt) begin
            fail_count++;
            $display("%0t chk: mismatch expected kind=%0d code=%h ctrl=%b alt=%b",
                     $time, want.kind, want.char_code, want.ctrl, want.alt);
            $display("%0t chk:          actual   kind=%0d code=%h ctrl=%b alt=%b",
                     $time, got.kind, got.char_code, got.ctrl, got.alt);
          end
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_keys.size();
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the key decoder: reset, byte stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import tksd_pkg::*;
  import tksd_tb_pkg::*;

  localparam int unsigned ParamLimit = 7;
  localparam int RandomItems = 750;
  localparam int CycleLimit  = 300000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  key_kind;
  logic [20:0] char_code;
  logic        ctrl_mod;
  logic        alt_mod;

  int fail_count;
  int pending;
  int cycle_count;
  int items_sent;
  int gap_pct;
  int stall_pct;

  terminal_key_sequence_decoder #(
    .PARAM_LIMIT(ParamLimit)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .key_kind_o  (key_kind),
    .char_code_o (char_code),
    .ctrl_mod_o  (ctrl_mod),
    .alt_mod_o   (alt_mod)
  );

  tksd_checker #(
    .PARAM_LIMIT(ParamLimit)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .req_type_i   (req_type),
    .in_byte_i    (in_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .key_kind_i   (key_kind),
    .char_code_i  (char_code),
    .ctrl_mod_i   (ctrl_mod),
    .alt_mod_i    (alt_mod),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side back-pressure.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Called just after a rising edge; returns at the edge that accepts the transaction.
  task automatic send(input logic req, input logic [7:0] b);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(ReqByte, b);
  endtask

  task automatic send_idle();
    send(ReqIdle, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return ByteUp;
      1: return ByteDown;
      2: return ByteRight;
      3: return ByteLeft;
      4: return ByteHome;
      5: return ByteEnd;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic utf8_sequence();
    int n;
    int cut;
    logic [7:0] lead;
    n   = $urandom_range(1, 3);
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n + 1;
    case (n)
      1: lead = 8'($urandom_range(ByteLead2, ByteLead3 - 1));
      2: lead = 8'($urandom_range(ByteLead3, ByteLead4 - 1));
      default: lead = 8'($urandom_range(ByteLead4, 8'hFF));
    endcase
    send_byte(lead);
    for (int i = 1; i <= n; i++) begin
      if (i == cut) begin
        send_idle();
        break;
      end
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(ByteCont | 8'($urandom_range(0, 63)));
    end
  endtask

  task automatic csi_param_sequence();
    int n;
    int r;
    send_byte(ByteEsc);
    send_byte(ByteCsi);
    send_byte(8'($urandom_range(ByteDigit0, ByteDigit9)));
    n = $urandom_range(0, 6);
    if (n >= 2 && $urandom_range(0, 1) == 0) begin
      send_byte(ByteSemi);
      send_byte(ByteDigit5);
      n -= 2;
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r < 8) send_byte(ByteSemi);
      else if (r < 13) send_byte(ByteDigit5);
      else if (r < 17) send_byte(8'($urandom_range(ByteDigit0, ByteDigit9)));
      else if (r < 19) send_byte(8'($urandom_range(0, ByteFinalMin - 1)));
      else begin
        send_idle();
        return;
      end
    end
    r = $urandom_range(0, 9);
    if (r < 5) send_byte(8'($urandom_range(ByteUp, ByteLeft)));
    else if (r < 7) send_byte(ByteTilde);
    else if (r == 7) send_idle();
    else send_byte(8'($urandom_range(ByteFinalMin, 8'hFF)));
  endtask

  task automatic random_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (r < 18) begin
      case ($urandom_range(0, 3))
        0: send_byte(ByteCr);
        1: send_byte(ByteTab);
        2: send_byte(ByteDel);
        default: send_byte(8'($urandom_range(0, ByteSpace - 1)));
      endcase
    end else if (r < 23) begin
      send_idle();
    end else if (r < 38) begin
      utf8_sequence();
    end else if (r < 46) begin
      send_byte(ByteEsc);
      case ($urandom_range(0, 3))
        0: send_byte(ByteEsc);
        1: send_idle();
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end else if (r < 66) begin
      send_byte(ByteEsc);
      send_byte((r < 57) ? ByteCsi : ByteSs3);
      if ($urandom_range(0, 7) == 0) send_idle();
      else send_byte(pick_letter());
    end else begin
      csi_param_sequence();
    end
  endtask

  task automatic directed_items();
    send_idle();
    send_byte(ByteNul);
    send_byte(ByteCr);
    send_byte(ByteTab);
    send_byte(ByteDel);
    send_byte(ByteCont);
    // lead byte above 0xF7 with continuations of mixed top bits
    send_byte(8'hFF);
    send_byte(8'hBF);
    send_byte(8'h7F);
    send_byte(8'hFF);
    // partial codepoint flushed by idle
    send_byte(8'hE2);
    send_byte(8'h82);
    send_idle();
    send_byte(ByteEsc);
    send_idle();
    send_byte(ByteEsc);
    send_byte(ByteEsc);
    send_byte(ByteEsc);
    send_byte(ByteCsi);
    send_byte(ByteDigit1);
    send_byte(ByteSemi);
    send_byte(ByteDigit5);
    send_byte(ByteUp);
    send_byte(ByteEsc);
    send_byte(ByteCsi);
    send_byte(ByteDigit3);
    send_byte(ByteTilde);
  endtask

  initial begin
    int band;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    req_type    <= 1'b0;
    in_byte     <= '0;
    out_ready   <= 1'b0;
    cycle_count  = 0;
    items_sent   = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    band         = -1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    while (items_sent < RandomItems) begin
      if (items_sent >= RandomItems - 100) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (items_sent / 100 != band) begin
        band = items_sent / 100;
        case ($urandom_range(0, 4))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 25; stall_pct = 0;  end
          2: begin gap_pct = 0;  stall_pct = 25; end
          3: begin gap_pct = 40; stall_pct = 40; end
          default: begin gap_pct = 10; stall_pct = 10; end
        endcase
      end
      random_sequence();
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
